### rtl/nv21iag_pkg.sv
package nv21iag_pkg;

	// Frame dimensions are saturated to this size before any use.
	localparam int unsigned MAX_DIM = 4096;

	// Field widths.
	localparam int unsigned COORD_W  = 7;
	localparam int unsigned COEF_W   = 32;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned POS_W    = 12;
	localparam int unsigned LUMA_W   = 24;
	localparam int unsigned CHROMA_W = 25;
	localparam int unsigned FRAC_W   = 16;

	// Configuration port widths.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Internal Q16.16 arithmetic widths: one coordinate times one coefficient,
	// and a sum of two such terms plus the offset.
	localparam int unsigned PROD_W = COORD_W + 1 + COEF_W;
	localparam int unsigned SUM_W  = PROD_W + 3;
	localparam int unsigned INT_W  = SUM_W - FRAC_W + 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_COEF_COS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd6;

	// Camera rotation codes.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_270  = 2'd2;

	// Reset values of the registers.
	localparam logic [COEF_W-1:0] COEF_COS_RESET     = 32'd65536;
	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [COORD_W-1:0] dst_col;
		logic [COORD_W-1:0] dst_row;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]    src_col;
		logic [POS_W-1:0]    src_row;
		logic [LUMA_W-1:0]   luma_index;
		logic [CHROMA_W-1:0] chroma_index;
	} out_item_t;

	// Saturate a frame dimension to 1..MAX_DIM.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/nv21iag_stream_if.sv
interface nv21iag_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### rtl/nv21_inverse_affine_address_gen.sv
// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------
// pix       | sink      | dst_col, dst_row (destination patch coordinate)
// addr      | source    | src_col, src_row, luma_index, chroma_index
// cfg       | write     | cfg_wr_en, cfg_index, cfg_data (no read-back)
//
// Every item passes through six register stages: coefficient products, the two
// Q16.16 sums, rotation, truncation and clamp, address products, final adds.
// One item is accepted per cycle while the output is not stalled.
// Each stage holds its item while the stage after it is full and stalled, so
// empty stages keep filling while a result waits at the output register.
// arst_n clears all valid bits and loads the register reset values.
module nv21_inverse_affine_address_gen (
	input  logic                                   clk,
	input  logic                                   arst_n,
	nv21iag_stream_if.sink                         pix,
	nv21iag_stream_if.source                       addr,
	input  logic                                   cfg_wr_en,
	input  logic [nv21iag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nv21iag_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned COORD_W  = nv21iag_pkg::COORD_W;
	localparam int unsigned COEF_W   = nv21iag_pkg::COEF_W;
	localparam int unsigned DIM_W    = nv21iag_pkg::DIM_W;
	localparam int unsigned POS_W    = nv21iag_pkg::POS_W;
	localparam int unsigned LUMA_W   = nv21iag_pkg::LUMA_W;
	localparam int unsigned CHROMA_W = nv21iag_pkg::CHROMA_W;
	localparam int unsigned FRAC_W   = nv21iag_pkg::FRAC_W;
	localparam int unsigned PROD_W   = nv21iag_pkg::PROD_W;
	localparam int unsigned SUM_W    = nv21iag_pkg::SUM_W;
	localparam int unsigned INT_W    = nv21iag_pkg::INT_W;

	// Configuration registers; frame sizes are stored already saturated.
	logic signed [COEF_W-1:0] coef_cos_q;
	logic signed [COEF_W-1:0] coef_sin_q;
	logic signed [COEF_W-1:0] offset_x_q;
	logic signed [COEF_W-1:0] offset_y_q;
	logic [DIM_W-1:0]         frame_width_q;
	logic [DIM_W-1:0]         frame_height_q;
	logic [1:0]               rotation_q;

	// Pipeline valid bits and stage enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	// Stage payloads.
	logic signed [PROD_W-1:0] p_xc_s1, p_ys_s1, p_yc_s1, p_xs_s1;
	logic signed [SUM_W-1:0]  sx_s2, sy_s2;
	logic signed [SUM_W-1:0]  qcol_s3, qrow_s3;
	logic [POS_W-1:0]         col_s4, row_s4;
	logic [POS_W-1:0]         col_s5, row_s5;
	logic [CHROMA_W-1:0]      luma_p_s5, rowhalf_p_s5, area_s5;
	nv21iag_pkg::out_item_t   item_s6;

	// Combinational helpers.
	logic [DIM_W-1:0]        w_m1, h_m1;
	logic signed [SUM_W-1:0] w_m1_q, h_m1_q;
	logic signed [SUM_W-1:0] qcol_d, qrow_d;
	logic [POS_W-1:0]        col_d, row_d;
	logic signed [COORD_W:0] x_sd, y_sd;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cos_q     <= nv21iag_pkg::COEF_COS_RESET;
			coef_sin_q     <= '0;
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			frame_width_q  <= nv21iag_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= nv21iag_pkg::FRAME_HEIGHT_RESET;
			rotation_q     <= nv21iag_pkg::ROT_NONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nv21iag_pkg::REG_COEF_COS:     coef_cos_q <= cfg_data[COEF_W-1:0];
				nv21iag_pkg::REG_COEF_SIN:     coef_sin_q <= cfg_data[COEF_W-1:0];
				nv21iag_pkg::REG_OFFSET_X:     offset_x_q <= cfg_data[COEF_W-1:0];
				nv21iag_pkg::REG_OFFSET_Y:     offset_y_q <= cfg_data[COEF_W-1:0];
				nv21iag_pkg::REG_FRAME_WIDTH:
					frame_width_q <= nv21iag_pkg::sat_dim(cfg_data[DIM_W-1:0]);
				nv21iag_pkg::REG_FRAME_HEIGHT:
					frame_height_q <= nv21iag_pkg::sat_dim(cfg_data[DIM_W-1:0]);
				nv21iag_pkg::REG_ROTATION:     rotation_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// A stage advances when the stage after it is empty or advancing itself.
	assign en_s6     = !v_s6 || addr.ready;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pix.ready = en_s1;

	assign addr.valid = v_s6;
	assign addr.item  = item_s6;

	// Valid bits travel with their items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	assign x_sd   = $signed({1'b0, pix.item.dst_col});
	assign y_sd   = $signed({1'b0, pix.item.dst_row});
	assign w_m1   = frame_width_q - DIM_W'(1);
	assign h_m1   = frame_height_q - DIM_W'(1);
	assign w_m1_q = $signed({{(SUM_W-DIM_W-FRAC_W){1'b0}}, w_m1, {FRAC_W{1'b0}}});
	assign h_m1_q = $signed({{(SUM_W-DIM_W-FRAC_W){1'b0}}, h_m1, {FRAC_W{1'b0}}});

	// Rotation mapping on the exact Q16.16 source position.
	always_comb begin
		case (rotation_q)
			nv21iag_pkg::ROT_90: begin
				qcol_d = sy_s2;
				qrow_d = h_m1_q - sx_s2;
			end
			nv21iag_pkg::ROT_270: begin
				qcol_d = w_m1_q - sy_s2;
				qrow_d = sx_s2;
			end
			default: begin
				qcol_d = sx_s2;
				qrow_d = sy_s2;
			end
		endcase
	end

	// Truncate toward zero, then clamp into 0..limit-1.
	function automatic logic [POS_W-1:0] trunc_clamp(
		input logic signed [SUM_W-1:0] v,
		input logic [DIM_W-1:0]         lim_m1
	);
		logic signed [INT_W-1:0] q;
		logic [POS_W-1:0]        r;
		q = INT_W'(v >>> FRAC_W);
		if (v[SUM_W-1] && (v[FRAC_W-1:0] != '0)) begin
			q = q + INT_W'(1);
		end
		if (q < 0) begin
			r = '0;
		end else if (q > $signed({{(INT_W-DIM_W){1'b0}}, lim_m1})) begin
			r = lim_m1[POS_W-1:0];
		end else begin
			r = q[POS_W-1:0];
		end
		return r;
	endfunction

	assign col_d = trunc_clamp(qcol_s3, w_m1);
	assign row_d = trunc_clamp(qrow_s3, h_m1);

	// Stage payload registers.
	always_ff @(posedge clk) begin
		// Stage 1: the four coordinate-by-coefficient products.
		if (en_s1) begin
			p_xc_s1 <= x_sd * coef_cos_q;
			p_ys_s1 <= y_sd * coef_sin_q;
			p_yc_s1 <= y_sd * coef_cos_q;
			p_xs_s1 <= x_sd * coef_sin_q;
		end
		// Stage 2: source position in Q16.16.
		if (en_s2) begin
			sx_s2 <= SUM_W'(p_xc_s1) + SUM_W'(p_ys_s1) + SUM_W'(offset_x_q);
			sy_s2 <= SUM_W'(p_yc_s1) - SUM_W'(p_xs_s1) + SUM_W'(offset_y_q);
		end
		// Stage 3: camera rotation.
		if (en_s3) begin
			qcol_s3 <= qcol_d;
			qrow_s3 <= qrow_d;
		end
		// Stage 4: integer column and row inside the frame.
		if (en_s4) begin
			col_s4 <= col_d;
			row_s4 <= row_d;
		end
		// Stage 5: stride products and plane size.
		if (en_s5) begin
			col_s5       <= col_s4;
			row_s5       <= row_s4;
			luma_p_s5    <= CHROMA_W'(row_s4) * CHROMA_W'(frame_width_q);
			rowhalf_p_s5 <= CHROMA_W'(row_s4[POS_W-1:1]) * CHROMA_W'(frame_width_q);
			area_s5      <= CHROMA_W'(frame_width_q) * CHROMA_W'(frame_height_q);
		end
		// Stage 6: byte indexes into the luma and interleaved chroma planes.
		if (en_s6) begin
			item_s6.src_col      <= col_s5;
			item_s6.src_row      <= row_s5;
			item_s6.luma_index   <= LUMA_W'(luma_p_s5 + CHROMA_W'(col_s5));
			item_s6.chroma_index <= area_s5 + rowhalf_p_s5
				+ CHROMA_W'({col_s5[POS_W-1:1], 1'b0});
		end
	end

endmodule

### tb/sv/nv21iag_address_checker.sv
// Watches both channels and the configuration port of the address generator.
// It keeps its own copy of the registers, predicts the address item for every
// accepted pixel item and compares each accepted address item with the oldest
// prediction.
module nv21iag_address_checker
	import nv21iag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_item,
	output int unsigned           mismatch_count,
	output int unsigned           pending_count
);

	localparam longint Q_ONE = 64'sd65536;

	// Shadow copies of the warp registers.
	logic [COEF_W-1:0] coef_cos;
	logic [COEF_W-1:0] coef_sin;
	logic [COEF_W-1:0] offset_x;
	logic [COEF_W-1:0] offset_y;
	logic [DIM_W-1:0]  frame_width;
	logic [DIM_W-1:0]  frame_height;
	logic [1:0]        rotation_mode;

	out_item_t   expected_addrs[$];
	int unsigned error_total = 0;

	// A zero frame size acts as one pixel and oversized frames stop at MAX_DIM.
	function automatic longint usable_dim(input logic [DIM_W-1:0] v);
		longint d;
		d = longint'(v);
		if (d < 1) begin
			d = 1;
		end else if (d > longint'(MAX_DIM)) begin
			d = longint'(MAX_DIM);
		end
		return d;
	endfunction

	// Maps one destination pixel back into the camera frame in exact Q16.16.
	function automatic out_item_t predict_address(input in_item_t pt);
		longint    x, y, c, s, w, h, sx, sy, col, row, luma, chroma;
		out_item_t r;
		x = longint'(pt.dst_col);
		y = longint'(pt.dst_row);
		c = longint'($signed(coef_cos));
		s = longint'($signed(coef_sin));
		w = usable_dim(frame_width);
		h = usable_dim(frame_height);
		sx = x * c + y * s + longint'($signed(offset_x));
		sy = y * c - x * s + longint'($signed(offset_y));

		// The unused rotation code falls back to no rotation.
		case (rotation_mode)
			ROT_90: begin
				col = sy / Q_ONE;
				row = ((h - 1) * Q_ONE - sx) / Q_ONE;
			end
			ROT_270: begin
				col = ((w - 1) * Q_ONE - sy) / Q_ONE;
				row = sx / Q_ONE;
			end
			default: begin
				col = sx / Q_ONE;
				row = sy / Q_ONE;
			end
		endcase

		if (col < 0) begin
			col = 0;
		end else if (col > w - 1) begin
			col = w - 1;
		end
		if (row < 0) begin
			row = 0;
		end else if (row > h - 1) begin
			row = h - 1;
		end

		// The chroma plane follows the luma plane; one V/U pair covers two columns.
		luma   = row * w + col;
		chroma = w * h + (row >>> 1) * w + (col & ~64'sd1);

		r.src_col      = POS_W'(col);
		r.src_row      = POS_W'(row);
		r.luma_index   = LUMA_W'(luma);
		r.chroma_index = CHROMA_W'(chroma);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_total++;
		end
	endtask

	// Register writes, predictions on the input side and checks on the output side.
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			coef_cos      <= COEF_COS_RESET;
			coef_sin      <= '0;
			offset_x      <= '0;
			offset_y      <= '0;
			frame_width   <= FRAME_WIDTH_RESET;
			frame_height  <= FRAME_HEIGHT_RESET;
			rotation_mode <= ROT_NONE;
			expected_addrs.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_COEF_COS:     coef_cos      <= cfg_data;
					REG_COEF_SIN:     coef_sin      <= cfg_data;
					REG_OFFSET_X:     offset_x      <= cfg_data;
					REG_OFFSET_Y:     offset_y      <= cfg_data;
					REG_FRAME_WIDTH:  frame_width   <= cfg_data[DIM_W-1:0];
					REG_FRAME_HEIGHT: frame_height  <= cfg_data[DIM_W-1:0];
					REG_ROTATION:     rotation_mode <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_addrs.size() == 0) begin
					$error("addr_out: item arrived with no expectation pending");
					error_total++;
				end else begin
					want = expected_addrs.pop_front();
					check_field("src_col", 32'(want.src_col), 32'(out_item.src_col));
					check_field("src_row", 32'(want.src_row), 32'(out_item.src_row));
					check_field("luma_index", 32'(want.luma_index),
						32'(out_item.luma_index));
					check_field("chroma_index", 32'(want.chroma_index),
						32'(out_item.chroma_index));
				end
			end

			if (in_valid && in_ready) begin
				expected_addrs.push_back(predict_address(in_item));
			end

			mismatch_count <= error_total;
			pending_count  <= expected_addrs.size();
		end
	end

endmodule

### tb/sv/tb.sv
// Top of the address generator testbench: clock, reset, stimulus, the output
// stall pattern and the verdict. Prediction and checking sit in the checker.
module tb;
	import nv21iag_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int PIPE_LATENCY  = 6;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
	localparam int PATCH_SIZE    = 112;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 100;
	localparam int HOLD_PHASE    = 5;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;

	// Index with no register behind it, and the rotation code with no meaning.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [1:0]           ROT_SPARE = 2'd3;

	typedef enum {SET_PLAUSIBLE, SET_WILD, SET_EDGES} setting_kind_t;

	typedef struct packed {
		logic [COEF_W-1:0]           coef_cos;
		logic [COEF_W-1:0]           coef_sin;
		logic [COEF_W-1:0]           offset_x;
		logic [COEF_W-1:0]           offset_y;
		logic [DIM_W-1:0]            frame_width;
		logic [DIM_W-1:0]            frame_height;
		logic [1:0]                  rotation_mode;
		logic [CFG_DATA_W-DIM_W-1:0] high_bits;
	} warp_setting_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int unsigned           mismatch_count;
	int unsigned           pending_count;
	int unsigned           cycle_count  = 0;
	int unsigned           hold_request = 0;
	int unsigned           hold_served  = 0;

	nv21iag_stream_if #(.item_t(in_item_t))  pix_in_if ();
	nv21iag_stream_if #(.item_t(out_item_t)) addr_out_if ();

	nv21_inverse_affine_address_gen DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_in_if),
		.addr      (addr_out_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nv21iag_address_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (pix_in_if.valid),
		.in_ready       (pix_in_if.ready),
		.in_item        (pix_in_if.item),
		.out_valid      (addr_out_if.valid),
		.out_ready      (addr_out_if.ready),
		.out_item       (addr_out_if.item),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Holds the write enable high; the caller lowers it after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Unused data bits above the size and rotation fields carry junk on purpose.
	task automatic apply_setting(input warp_setting_t s);
		write_reg(REG_COEF_COS, s.coef_cos);
		write_reg(REG_COEF_SIN, s.coef_sin);
		write_reg(REG_OFFSET_X, s.offset_x);
		write_reg(REG_OFFSET_Y, s.offset_y);
		write_reg(REG_FRAME_WIDTH, {s.high_bits, s.frame_width});
		write_reg(REG_FRAME_HEIGHT, {s.high_bits, s.frame_height});
		write_reg(REG_ROTATION, {s.high_bits, s.high_bits[10:0], s.rotation_mode});
		cfg_wr_en <= 1'b0;
	endtask

	// Offers one pixel item and returns at the edge that accepts it, valid still high.
	task automatic send_pixel(input in_item_t pt);
		pix_in_if.valid <= 1'b1;
		pix_in_if.item  <= pt;
		do begin
			@(posedge clk);
		end while (!pix_in_if.ready);
	endtask

	// Stops offering and waits for every predicted address item to come out.
	task automatic drain_results();
		pix_in_if.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The four corners of the 7-bit coordinate space, back to back.
	task automatic send_corners();
		in_item_t pt;
		for (int k = 0; k < 4; k++) begin
			pt.dst_col = (k % 2 == 1) ? 7'h7F : 7'h00;
			pt.dst_row = (k / 2 == 1) ? 7'h7F : 7'h00;
			send_pixel(pt);
		end
	endtask

	// Most coordinates lie inside the patch, some beyond it.
	function automatic in_item_t random_pixel();
		in_item_t pt;
		if ($urandom_range(0, 7) == 0) begin
			pt.dst_col = COORD_W'($urandom_range(PATCH_SIZE, 127));
		end else begin
			pt.dst_col = COORD_W'($urandom_range(0, PATCH_SIZE - 1));
		end
		if ($urandom_range(0, 7) == 0) begin
			pt.dst_row = COORD_W'($urandom_range(PATCH_SIZE, 127));
		end else begin
			pt.dst_row = COORD_W'($urandom_range(0, PATCH_SIZE - 1));
		end
		return pt;
	endfunction

	function automatic warp_setting_t random_setting(input setting_kind_t kind);
		warp_setting_t     s;
		int unsigned       mag;
		logic [DIM_W-1:0]  dim_edges[6]  = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'd4097, 13'h1FFF};
		logic [COEF_W-1:0] coef_edges[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
			32'h0001_0000, 32'hFFFF_0000};
		s = '0;
		s.rotation_mode = 2'($urandom_range(0, 3));
		case (kind)
			// A scaled rotation with the translation landing near the frame.
			SET_PLAUSIBLE: begin
				s.frame_width  = DIM_W'($urandom_range(16, 4096));
				s.frame_height = DIM_W'($urandom_range(16, 4096));
				mag = $urandom_range(0, 4 * 65536);
				s.coef_cos = ($urandom_range(0, 1) == 1) ? -mag : mag;
				mag = $urandom_range(0, 2 * 65536);
				s.coef_sin = ($urandom_range(0, 1) == 1) ? -mag : mag;
				s.offset_x = $urandom_range(0, s.frame_width * 65536)
					- $urandom_range(0, 16 * 65536);
				s.offset_y = $urandom_range(0, s.frame_height * 65536)
					- $urandom_range(0, 16 * 65536);
			end
			SET_WILD: begin
				s.coef_cos     = $urandom();
				s.coef_sin     = $urandom();
				s.offset_x     = $urandom();
				s.offset_y     = $urandom();
				s.frame_width  = DIM_W'($urandom());
				s.frame_height = DIM_W'($urandom());
				s.high_bits    = (CFG_DATA_W - DIM_W)'($urandom());
			end
			default: begin
				s.coef_cos     = coef_edges[$urandom_range(0, 4)];
				s.coef_sin     = coef_edges[$urandom_range(0, 4)];
				s.offset_x     = coef_edges[$urandom_range(0, 4)];
				s.offset_y     = coef_edges[$urandom_range(0, 4)];
				s.frame_width  = dim_edges[$urandom_range(0, 5)];
				s.frame_height = dim_edges[$urandom_range(0, 5)];
			end
		endcase
		return s;
	endfunction

	// Random pixel items, either in bursts with gaps or as one unbroken stream.
	task automatic send_phase(input int count, input bit bursty);
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (bursty && burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					pix_in_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 32);
			end
			send_pixel(random_pixel());
			if (burst_left != 0) begin
				burst_left--;
			end
		end
	endtask

	// Output stall pattern: stretches of steady, sparse, dense or periodic ready,
	// plus a long hold-off whenever the stimulus asks for one.
	initial begin : receiver
		int unsigned mode;
		int unsigned stretch;
		addr_out_if.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request != hold_served) begin
				addr_out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = hold_request;
			end else begin
				mode    = $urandom_range(0, 3);
				stretch = $urandom_range(1, 40);
				for (int k = 0; k < stretch; k++) begin
					case (mode)
						0: addr_out_if.ready <= 1'b1;
						1: addr_out_if.ready <= ($urandom_range(0, 3) != 0);
						2: addr_out_if.ready <= ($urandom_range(0, 3) == 0);
						default: addr_out_if.ready <= (k % 3 == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		warp_setting_t directed_setups[5];
		setting_kind_t kind;

		pix_in_if.valid = 1'b0;
		pix_in_if.item  = '0;

		// Saturated sizes, coefficient and offset extremes, both rotations,
		// the unused rotation code, and one setting that maps inside the frame.
		directed_setups[0] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			13'h1FFF, 13'd0, ROT_90, '0};
		directed_setups[1] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			13'd4096, 13'd4096, ROT_270, '0};
		directed_setups[2] = '{32'hFFFF_0000, 32'h0000_8000, 32'h0040_0000, 32'h0020_0000,
			13'd1, 13'h1FFF, ROT_SPARE, '0};
		directed_setups[3] = '{32'h0000_8000, 32'h0, 32'h000A_8000, 32'h0005_4000,
			13'd4097, 13'd100, ROT_NONE, '0};
		directed_setups[4] = '{32'h0001_0000, 32'h0, 32'h0014_0000, 32'h001E_0000,
			13'd200, 13'd180, ROT_90, '0};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: the reset setting first, then the fixed setups.
		send_corners();
		for (int i = 0; i < 5; i++) begin
			drain_results();
			if (i == 0) begin
				write_reg(REG_SPARE, 32'hFFFF_FFFF);
			end
			apply_setting(directed_setups[i]);
			send_corners();
		end

		// Random part: a new setting per phase, one phase under a long output hold.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0, 1: kind = SET_PLAUSIBLE;
				2: kind = SET_WILD;
				default: kind = SET_EDGES;
			endcase
			drain_results();
			apply_setting(random_setting(kind));
			if (p == HOLD_PHASE) begin
				hold_request <= hold_request + 1;
				send_phase(PHASE_ITEMS, 1'b0);
			end else begin
				send_phase(PHASE_ITEMS, 1'b1);
			end
		end

		drain_results();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
